[hw/rtl/cnv_pkg.sv]
// ----------------------------------------------------------------------------
// cnv_pkg: shared types and constants of the streaming 2-D convolution
// Holds the word types of both channels, the derived configuration, the
// job descriptor passed from front to back and the storage write command.
// ----------------------------------------------------------------------------
package cnv_pkg;

   localparam int MAX_KERNEL   = 5;
   localparam int MAX_WIDTH    = 32;
   localparam int MAX_HEIGHT   = 64;
   localparam int KERNEL_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH;
   localparam int TAP_AW       = $clog2(KERNEL_DEPTH);
   localparam int LINE_AW      = $clog2(LINE_DEPTH);
   localparam int SLOT_W       = $clog2(MAX_KERNEL);
   localparam int XW           = $clog2(MAX_WIDTH);
   localparam int CSR_IW       = 3;
   localparam int CSR_DW       = 7;

   localparam logic [CSR_IW-1:0] REG_KERNEL_ROWS = 3'd0;
   localparam logic [CSR_IW-1:0] REG_KERNEL_COLS = 3'd1;
   localparam logic [CSR_IW-1:0] REG_IMAGE_ROWS  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_IMAGE_COLS  = 3'd3;
   localparam logic [CSR_IW-1:0] REG_CROP_MODE   = 3'd4;
   localparam logic [CSR_IW-1:0] REG_FLIP_KERNEL = 3'd5;

   localparam logic [1:0] CROP_SAME  = 2'd1;
   localparam logic [1:0] CROP_VALID = 2'd2;

   typedef enum logic [1:0] {
      OP_WEIGHT = 2'd0,
      OP_PIXEL  = 2'd1,
      OP_FLUSH  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_TAPS,
      B_DRAIN,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [4:0]         weight_index;
      logic signed [15:0] data_value;
   } req_type;

   typedef struct packed {
      logic signed [35:0] out_value;
      logic [6:0]         out_row;
      logic [5:0]         out_col;
      logic               run_last;
      logic               frame_end;
   } rsp_type;

   typedef struct packed {
      logic [2:0] kr;
      logic [2:0] kc;
      logic [6:0] ih;
      logic [5:0] iw;
      logic       flip;
      logic [6:0] orows;
      logic [5:0] ocols;
      logic [2:0] crop_r;
      logic [2:0] crop_c;
      logic [4:0] taps;
   } cfg_type;

   typedef struct packed {
      logic [6:0]        row;
      logic [5:0]        first;
      logic [5:0]        last;
      logic [SLOT_W-1:0] slot;
   } job_type;

   typedef struct packed {
      logic               kern_we;
      logic [TAP_AW-1:0]  kern_addr;
      logic               line_we;
      logic [LINE_AW-1:0] line_addr;
      logic [15:0]        data;
   } wr_type;

endpackage

[hw/rtl/cnv_front.sv]
// ----------------------------------------------------------------------------
// cnv_front: word intake, configuration and frame counters
// Classifies each word, issues storage writes and queues one job per word
// that produces results, describing the run of output columns to compute.
// ----------------------------------------------------------------------------
module cnv_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cnv_pkg::CSR_IW-1:0]   csr_index,
   input  logic [cnv_pkg::CSR_DW-1:0]   csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  cnv_pkg::req_type             req_data,
   input  logic                         q_empty,
   input  logic                         back_idle,
   output logic                         push,
   output cnv_pkg::job_type             job,
   output cnv_pkg::wr_type              wr,
   output cnv_pkg::cfg_type             cfg
);
   import cnv_pkg::*;

   logic [2:0] kr_raw_ff, kc_raw_ff;
   logic [6:0] ih_raw_ff;
   logic [5:0] iw_raw_ff;
   logic [1:0] mode_ff;
   logic       flip_ff;

   logic [6:0]        pixel_row_ff, pixel_row_in;
   logic [5:0]        pixel_col_ff, pixel_col_in;
   logic [2:0]        flush_row_ff, flush_row_in;
   logic [5:0]        flush_col_ff, flush_col_in;
   logic [SLOT_W-1:0] row_slot_ff, row_slot_in;

   logic       both_even;
   logic [2:0] hh, hw;
   logic       accept;
   logic [6:0] j_row;
   logic [5:0] col_lo, col_hi, first, last, col_max;
   logic       row_in, want;
   logic [3:0] base;
   logic [SLOT_W-1:0] slot_next;

   // Derived configuration, with out-of-range values clamped.
   always_comb begin
      cfg.kr   = (kr_raw_ff == 3'd0) ? 3'd1 :
                 (kr_raw_ff > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kr_raw_ff;
      cfg.kc   = (kc_raw_ff == 3'd0) ? 3'd1 :
                 (kc_raw_ff > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kc_raw_ff;
      cfg.ih   = (ih_raw_ff == 7'd0) ? 7'd1 :
                 (ih_raw_ff > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : ih_raw_ff;
      cfg.iw   = (iw_raw_ff == 6'd0) ? 6'd1 :
                 (iw_raw_ff > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : iw_raw_ff;
      cfg.flip = flip_ff;
      cfg.orows = cfg.ih + 7'(cfg.kr) - 7'd1;
      cfg.ocols = cfg.iw + 6'(cfg.kc) - 6'd1;
      both_even = !cfg.kr[0] && !cfg.kc[0];
      hh = both_even ? (cfg.kr >> 1) : ((cfg.kr - 3'd1) >> 1);
      hw = both_even ? (cfg.kc >> 1) : ((cfg.kc - 3'd1) >> 1);
      cfg.crop_r = 3'd0;
      cfg.crop_c = 3'd0;
      if (mode_ff == CROP_SAME) begin
         cfg.crop_r = hh;
         cfg.crop_c = hw;
      end else if (mode_ff == CROP_VALID) begin
         cfg.crop_r = both_even ? (3'(hh << 1) - 3'd1) : 3'(hh << 1);
         cfg.crop_c = both_even ? (3'(hw << 1) - 3'd1) : 3'(hw << 1);
      end
      cfg.taps = 5'(cfg.kr) * 5'(cfg.kc);
   end

   // A new word is taken only once every earlier job has been computed, so
   // storage writes never disturb a window still being summed.
   assign req_ready = q_empty && back_idle;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pixel_row_in = pixel_row_ff;
      pixel_col_in = pixel_col_ff;
      flush_row_in = flush_row_ff;
      flush_col_in = flush_col_ff;
      row_slot_in  = row_slot_ff;
      wr           = '0;
      wr.data      = req_data.data_value;
      want         = 1'b0;
      j_row        = pixel_row_ff;
      col_lo       = pixel_col_ff;
      col_hi       = pixel_col_ff;
      slot_next    = (row_slot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0 : row_slot_ff + 1'b1;

      if (accept) begin
         unique case (opcode_type'(req_data.opcode))
            OP_WEIGHT: begin
               if (req_data.weight_index < 5'(KERNEL_DEPTH)) begin
                  wr.kern_we   = 1'b1;
                  wr.kern_addr = TAP_AW'(req_data.weight_index);
               end
            end
            OP_PIXEL: begin
               if (pixel_row_ff < cfg.ih && pixel_col_ff < cfg.iw) begin
                  wr.line_we   = 1'b1;
                  wr.line_addr = LINE_AW'(row_slot_ff) * LINE_AW'(MAX_WIDTH)
                                 + LINE_AW'(pixel_col_ff);
                  want   = 1'b1;
                  col_hi = (pixel_col_ff == cfg.iw - 6'd1) ? cfg.ocols - 6'd1
                                                           : pixel_col_ff;
                  pixel_col_in = pixel_col_ff + 6'd1;
                  if (pixel_col_ff + 6'd1 >= cfg.iw) begin
                     pixel_col_in = '0;
                     pixel_row_in = pixel_row_ff + 7'd1;
                     row_slot_in  = slot_next;
                     if (pixel_row_ff + 7'd1 >= cfg.ih && cfg.kr == 3'd1) begin
                        pixel_row_in = '0;
                        row_slot_in  = '0;
                     end
                  end
               end
            end
            OP_FLUSH: begin
               if (pixel_row_ff >= cfg.ih && cfg.kr != 3'd1) begin
                  want   = 1'b1;
                  j_row  = cfg.ih + 7'(flush_row_ff);
                  col_lo = flush_col_ff;
                  col_hi = flush_col_ff;
                  flush_col_in = flush_col_ff + 6'd1;
                  if (flush_col_ff + 6'd1 >= cfg.ocols) begin
                     flush_col_in = '0;
                     flush_row_in = flush_row_ff + 3'd1;
                     row_slot_in  = slot_next;
                     if (flush_row_ff + 3'd1 >= cfg.kr - 3'd1) begin
                        pixel_row_in = '0;
                        pixel_col_in = '0;
                        flush_row_in = '0;
                        row_slot_in  = '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (csr_write_en) begin
         pixel_row_in = '0;
         pixel_col_in = '0;
         flush_row_in = '0;
         flush_col_in = '0;
         row_slot_in  = '0;
      end

      // Clip the column run and the row against the crop window.
      row_in  = (j_row >= 7'(cfg.crop_r)) && (j_row < cfg.orows - 7'(cfg.crop_r));
      col_max = cfg.ocols - 6'd1 - 6'(cfg.crop_c);
      first   = (col_lo > 6'(cfg.crop_c)) ? col_lo : 6'(cfg.crop_c);
      last    = (col_hi < col_max) ? col_hi : col_max;
      push    = want && row_in && (first <= last);

      // Line slot of the top window row, row - kr + 1, modulo the slot count.
      base = 4'(row_slot_ff) + 4'(MAX_KERNEL + 1) - 4'(cfg.kr);
      if (base >= 4'(MAX_KERNEL)) begin
         base = base - 4'(MAX_KERNEL);
      end
      job.row   = j_row;
      job.first = first;
      job.last  = last;
      job.slot  = SLOT_W'(base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kr_raw_ff    <= 3'd3;
         kc_raw_ff    <= 3'd3;
         ih_raw_ff    <= 7'd32;
         iw_raw_ff    <= 6'd32;
         mode_ff      <= 2'd0;
         flip_ff      <= 1'b1;
         pixel_row_ff <= '0;
         pixel_col_ff <= '0;
         flush_row_ff <= '0;
         flush_col_ff <= '0;
         row_slot_ff  <= '0;
      end else begin
         pixel_row_ff <= pixel_row_in;
         pixel_col_ff <= pixel_col_in;
         flush_row_ff <= flush_row_in;
         flush_col_ff <= flush_col_in;
         row_slot_ff  <= row_slot_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_KERNEL_ROWS: kr_raw_ff <= csr_wdata[2:0];
               REG_KERNEL_COLS: kc_raw_ff <= csr_wdata[2:0];
               REG_IMAGE_ROWS:  ih_raw_ff <= csr_wdata[6:0];
               REG_IMAGE_COLS:  iw_raw_ff <= csr_wdata[5:0];
               REG_CROP_MODE:   mode_ff   <= csr_wdata[1:0];
               REG_FLIP_KERNEL: flip_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

[hw/rtl/cnv_queue.sv]
// ----------------------------------------------------------------------------
// cnv_queue: two-entry job queue between front and back
// Plain first-in first-out store of job descriptors.
// ----------------------------------------------------------------------------
module cnv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cnv_pkg::job_type job_in,
   input  logic             pop,
   output cnv_pkg::job_type job_out,
   output logic             empty,
   output logic             full
);
   import cnv_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign job_out = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[hw/rtl/cnv_back.sv]
// ----------------------------------------------------------------------------
// cnv_back: kernel and line storage with a shared multiply-accumulate
// Walks every kernel tap of each queued output position, one tap a cycle,
// and places the finished sum in the result register.
// ----------------------------------------------------------------------------
module cnv_back (
   input  logic             clock,
   input  logic             reset,
   input  cnv_pkg::cfg_type cfg,
   input  cnv_pkg::wr_type  wr,
   input  logic             q_empty,
   input  cnv_pkg::job_type q_job,
   output logic             pop,
   output logic             idle,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cnv_pkg::rsp_type rsp_data
);
   import cnv_pkg::*;

   logic [15:0] kern_mem [KERNEL_DEPTH];
   logic [15:0] line_mem [LINE_DEPTH];

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [5:0]        col_ff, col_in;
   logic [2:0]        r_ff, r_in, c_ff, c_in;
   logic signed [7:0] y_ff, y_in;
   logic signed [6:0] x_ff, x_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TAP_AW-1:0] t_ff, t_in;
   logic              drain_ff, drain_in;
   logic              acc_clr;

   logic               tap_v1_ff, tap_v1_in;
   logic signed [15:0] pix_ff, wgt_ff;
   logic signed [31:0] prod_ff;
   logic               prod_v_ff;
   logic signed [35:0] acc_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               tap_ok, load_rsp;
   logic [LINE_AW-1:0] rd_addr;
   logic [5:0]         start_col;
   job_type            start_job;
   logic               start;

   assign idle      = (state_ff == B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tap_ok  = (y_ff >= 8'sd0) && (y_ff < $signed({1'b0, cfg.ih}))
                 && (x_ff >= 7'sd0) && (x_ff < $signed({1'b0, cfg.iw}));
   assign rd_addr = LINE_AW'(slot_ff) * LINE_AW'(MAX_WIDTH) + LINE_AW'(x_ff[XW-1:0]);

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      col_in    = col_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      y_in      = y_ff;
      x_in      = x_ff;
      slot_in   = slot_ff;
      t_in      = t_ff;
      drain_in  = drain_ff;
      pop       = 1'b0;
      load_rsp  = 1'b0;
      start     = 1'b0;
      start_col = col_ff;
      start_job = job_ff;
      tap_v1_in = (state_ff == B_TAPS) && tap_ok;

      rsp_in.out_value = acc_ff;
      rsp_in.out_row   = job_ff.row - 7'(cfg.crop_r);
      rsp_in.out_col   = col_ff - 6'(cfg.crop_c);
      rsp_in.run_last  = (col_ff == job_ff.last);
      rsp_in.frame_end = (job_ff.row == cfg.orows - 7'd1 - 7'(cfg.crop_r))
                      && (col_ff == cfg.ocols - 6'd1 - 6'(cfg.crop_c));

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               start     = 1'b1;
               start_job = q_job;
               start_col = q_job.first;
            end
         end
         B_TAPS: begin
            t_in = cfg.flip ? t_ff - 1'b1 : t_ff + 1'b1;
            if (c_ff == cfg.kc - 3'd1) begin
               c_in    = '0;
               x_in    = $signed({1'b0, col_ff}) - $signed({4'b0, cfg.kc}) + 7'sd1;
               r_in    = r_ff + 3'd1;
               y_in    = y_ff + 8'sd1;
               slot_in = (slot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_ff + 1'b1;
               if (r_ff == cfg.kr - 3'd1) begin
                  state_in = B_DRAIN;
                  drain_in = 1'b0;
               end
            end else begin
               c_in = c_ff + 3'd1;
               x_in = x_ff + 7'sd1;
            end
         end
         B_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               if (col_ff == job_ff.last) begin
                  state_in = B_IDLE;
               end else begin
                  start     = 1'b1;
                  start_col = col_ff + 6'd1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      // Set up the tap walk of a new output position.
      if (start) begin
         state_in = B_TAPS;
         job_in   = start_job;
         col_in   = start_col;
         r_in     = '0;
         c_in     = '0;
         y_in     = $signed({1'b0, start_job.row}) - $signed({5'b0, cfg.kr}) + 8'sd1;
         x_in     = $signed({1'b0, start_col}) - $signed({4'b0, cfg.kc}) + 7'sd1;
         slot_in  = start_job.slot;
         t_in     = cfg.flip ? TAP_AW'(cfg.taps - 5'd1) : '0;
      end
      acc_clr = start;

      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Storage writes and registered reads.
   always_ff @(posedge clock) begin
      if (wr.kern_we) begin
         kern_mem[wr.kern_addr] <= wr.data;
      end
      wgt_ff <= kern_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (wr.line_we) begin
         line_mem[wr.line_addr] <= wr.data;
      end
      pix_ff <= line_mem[rd_addr];
   end

   // Datapath: product register, then accumulator.
   always_ff @(posedge clock) begin
      prod_ff <= pix_ff * wgt_ff;
      job_ff  <= job_in;
      col_ff  <= col_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      y_ff    <= y_in;
      x_ff    <= x_in;
      slot_ff <= slot_in;
      t_ff    <= t_in;
      drain_ff <= drain_in;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + {{4{prod_ff[31]}}, prod_ff};
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         tap_v1_ff    <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_v1_ff    <= tap_v1_in;
         prod_v_ff    <= tap_v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/conv2d_full_same_valid.sv]
// ----------------------------------------------------------------------------
// conv2d_full_same_valid: streaming 2-D convolution with full/same/valid crop
// Each result is summed one kernel tap per cycle through the single shared
// multiply-accumulate, and the results of one word are computed in turn.
// Throughput: the next word is taken once all results of the previous word
// are computed; words that produce no result are taken every cycle.
// Reset: synchronous, active high; registers return to 3x3 kernel, 32x32
// image, full output, convolution. Kernel and line storage are not cleared.
// ----------------------------------------------------------------------------
module conv2d_full_same_valid (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cnv_pkg::CSR_IW-1:0]   csr_index,
   input  logic [cnv_pkg::CSR_DW-1:0]   csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  cnv_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cnv_pkg::rsp_type             rsp_data
);
   import cnv_pkg::*;

   // The front takes each word, writes weights and pixels into storage and
   // turns a pixel or flush word into at most one job: an output row and the run of
   // columns that survive the crop window.
   cfg_type cfg;
   wr_type  wr;
   job_type push_job, pop_job;
   logic    push, pop, q_empty, q_full, back_idle;

   cnv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .q_empty      (q_empty),
      .back_idle    (back_idle),
      .push         (push),
      .job          (push_job),
      .wr           (wr),
      .cfg          (cfg)
   );

   // Jobs wait here until the back end is free.
   cnv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (push_job),
      .pop     (pop),
      .job_out (pop_job),
      .empty   (q_empty),
      .full    (q_full)
   );

   // The back end sums each output position tap by tap and holds the word
   // in its result register, so it may stall on the result side alone.
   cnv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .wr        (wr),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .pop       (pop),
      .idle      (back_idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The job queue is never pushed while full.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("job queue overflow");

   // The final output of the image always closes the run of its word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> rsp_data.run_last)
      else $error("frame end without run end");

   // A new word is never taken while a job is still queued or the back end is busy.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (q_empty && back_idle))
      else $error("word taken while back end busy");

endmodule
